[rtl/qte_pkg.sv]
// shared types, constants and the arctangent table for the quaternion to euler block
package qte_pkg;

  localparam int CW         = 34;
  localparam int ZW         = 32;
  localparam int AW         = 16;
  localparam int SQRT_BITS  = 31;
  localparam int REM_W      = 61;
  localparam int UNIT_W     = 32;
  localparam int PITCH_LEAD = 3 + SQRT_BITS;
  localparam int TABLE_SIZE = 24;
  localparam int NORM_MSB   = 29;
  localparam int UNIT_SHIFT = 60;

  localparam logic signed [ZW-1:0] Z_LIMIT    = 32'sd589824000;
  localparam logic signed [ZW-1:0] ROUND_HALF = 32'sd32768;
  localparam logic signed [AW-1:0] HALF_TURN  = 16'sd18000;
  localparam logic signed [AW-1:0] QUARTER    = 16'sd9000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 xneg;
    logic                 yneg;
  } rot_t;

  typedef struct packed {
    logic [REM_W-1:0]         rem;
    logic [SQRT_BITS-1:0]     root;
    logic signed [UNIT_W-1:0] yv;
  } root_t;

  // atan(2^-i) in 1/65536 centidegree
  function automatic logic signed [ZW-1:0] atan_angle(input int idx);
    case (idx)
      0:  return 32'sd294912000;
      1:  return 32'sd174096719;
      2:  return 32'sd91987925;
      3:  return 32'sd46694507;
      4:  return 32'sd23437865;
      5:  return 32'sd11730358;
      6:  return 32'sd5866610;
      7:  return 32'sd2933484;
      8:  return 32'sd1466764;
      9:  return 32'sd733385;
      10: return 32'sd366693;
      11: return 32'sd183346;
      12: return 32'sd91673;
      13: return 32'sd45837;
      14: return 32'sd22918;
      15: return 32'sd11459;
      16: return 32'sd5730;
      17: return 32'sd2865;
      18: return 32'sd1432;
      19: return 32'sd716;
      20: return 32'sd358;
      21: return 32'sd179;
      22: return 32'sd90;
      23: return 32'sd45;
      default: return '0;
    endcase
  endfunction

endpackage

[rtl/qte_cordic_cell.sv]
// one vectoring micro-rotation of the cordic chain
module qte_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          en,
  input  qte_pkg::rot_t din,
  output qte_pkg::rot_t dout
);
  import qte_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = atan_angle(STAGE);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  rot_t                 step;

  always_comb begin
    dx   = din.y >>> STAGE;
    dy   = din.x >>> STAGE;
    step = din;
    if (din.y[CW-1]) begin
      step.x = din.x - dx;
      step.y = din.y + dy;
      step.z = din.z - ANGLE;
    end else if (din.y != '0) begin
      step.x = din.x + dx;
      step.y = din.y - dy;
      step.z = din.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= step;
  end

endmodule

[rtl/qte_sqrt_cell.sv]
// one result bit of the restoring square root chain
module qte_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           en,
  input  qte_pkg::root_t din,
  output qte_pkg::root_t dout
);
  import qte_pkg::*;

  localparam int TW = REM_W + 2;

  logic [TW-1:0] trial;
  root_t         step;

  always_comb begin
    trial = (TW'(din.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    step  = din;
    if ({2'b00, din.rem} >= trial) begin
      step.rem  = din.rem - trial[REM_W-1:0];
      step.root = din.root | (SQRT_BITS'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= step;
  end

endmodule

[rtl/qte_atan2.sv]
// pipelined atan2: magnitude, normalise, cordic chain, round and quadrant fix
module qte_atan2 #(
  parameter int W    = 35,
  parameter int ITER = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [W-1:0]        yv,
  input  logic signed [W-1:0]        xv,
  output logic signed [qte_pkg::AW-1:0] angle
);
  import qte_pkg::*;

  localparam int NI = (ITER > TABLE_SIZE) ? TABLE_SIZE : ITER;
  localparam int PW = $clog2(W);

  logic [W-1:0]  ax0, ay0, ax1, ay1, nx, ny;
  logic          xn0, yn0, xn1, yn1;
  logic [PW-1:0] pos_c, pos, sh;
  rot_t          chain [NI+1];
  logic signed [ZW-1:0] zc, rnd;
  logic signed [AW-1:0] av;

  always_ff @(posedge clk) begin
    if (en) begin
      ax0 <= xv[W-1] ? $unsigned(-xv) : $unsigned(xv);
      ay0 <= yv[W-1] ? $unsigned(-yv) : $unsigned(yv);
      xn0 <= xv[W-1];
      yn0 <= yv[W-1];
    end
  end

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < W; i++) begin
      if (ax0[i] | ay0[i]) pos_c = PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos <= pos_c;
      ax1 <= ax0;
      ay1 <= ay0;
      xn1 <= xn0;
      yn1 <= yn0;
    end
  end

  always_comb begin
    if (pos < PW'(NORM_MSB)) begin
      sh = PW'(NORM_MSB) - pos;
      nx = ax1 << sh;
      ny = ay1 << sh;
    end else begin
      sh = pos - PW'(NORM_MSB);
      nx = ax1 >> sh;
      ny = ay1 >> sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].x    <= CW'(nx[NORM_MSB:0]);
      chain[0].y    <= CW'(ny[NORM_MSB:0]);
      chain[0].z    <= '0;
      chain[0].xneg <= xn1;
      chain[0].yneg <= yn1;
    end
  end

  for (genvar g = 0; g < NI; g++) begin : g_cell
    qte_cordic_cell #(.STAGE(g)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  always_comb begin
    zc = chain[NI].z;
    if (zc[ZW-1]) zc = '0;
    else if (zc > Z_LIMIT) zc = Z_LIMIT;
    rnd = zc + ROUND_HALF;
    av  = rnd[ZW-1:ZW-AW];
    if (chain[NI].xneg) av = HALF_TURN - av;
    if (chain[NI].yneg) av = -av;
  end

  always_ff @(posedge clk) begin
    if (en) angle <= av;
  end

endmodule

[rtl/quaternion_to_euler_angles.sv]
// top level: quaternion to zyx euler angles in centidegrees
// One quaternion is taken every clock cycle while the pipeline is not held.
// The pitch path is the longest: registers that form, saturate and square
// the sine and seed the root, a 31-cell square root chain, the atan2 pipeline,
// then the output register.
// Roll and yaw run through their own atan2 pipelines and wait in a delay line
// to line up with pitch. The whole pipeline holds while a finished result is
// stalled.
module quaternion_to_euler_angles #(
  parameter int CORDIC_ITERATIONS  = 16,
  parameter int QUAT_FRACTION_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               quat_valid,
  output logic               quat_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic               present,
  output logic               angle_valid,
  input  logic               angle_stall,
  output logic signed [15:0] roll_cdeg,
  output logic signed [14:0] pitch_cdeg,
  output logic signed [15:0] yaw_cdeg
);
  import qte_pkg::*;

  localparam int F2    = 2 * QUAT_FRACTION_BITS;
  localparam int OPW   = ((F2 > 32) ? F2 : 32) + 3;
  localparam int NI    = (CORDIC_ITERATIONS > TABLE_SIZE) ? TABLE_SIZE : CORDIC_ITERATIONS;
  localparam int DEPTH = NI + PITCH_LEAD + 7;
  localparam int SHR   = (F2 > 30) ? F2 - 30 : 0;
  localparam int SHL   = (F2 > 30) ? 0 : 30 - F2;
  localparam logic signed [OPW-1:0] ONE = OPW'(1) << F2;
  localparam logic [2*SQRT_BITS-1:0] UNIT_SQ = (2*SQRT_BITS)'(1) << UNIT_SHIFT;

  logic en;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  logic signed [OPW-1:0] roll_y, roll_x, yaw_y, yaw_x, sine;
  logic [OPW-1:0]        mag, sat;
  logic [OPW+15:0]       uw;
  logic [SQRT_BITS-1:0]  u1, u2;
  logic                  sn1, sn2;
  logic [2*SQRT_BITS-1:0] usq;
  root_t                 sq [SQRT_BITS+1];
  logic signed [AW-1:0]  roll_a, yaw_a, pitch_a;
  logic signed [AW-1:0]  roll_d [PITCH_LEAD];
  logic signed [AW-1:0]  yaw_d  [PITCH_LEAD];
  logic                  vld [DEPTH];
  logic                  pres [DEPTH-1];

  assign en          = !(vld[DEPTH-1] && angle_stall);
  assign quat_stall  = !en;
  assign angle_valid = vld[DEPTH-1];

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat_w * quat_x;
      p_yz <= quat_y * quat_z;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_zz <= quat_z * quat_z;
      p_wy <= quat_w * quat_y;
      p_zx <= quat_z * quat_x;
    end
  end

  // atan2 operands and pitch sine
  always_ff @(posedge clk) begin
    if (en) begin
      roll_y <= (OPW'(p_wx) + OPW'(p_yz)) <<< 1;
      roll_x <= ONE - ((OPW'(p_xx) + OPW'(p_yy)) <<< 1);
      yaw_y  <= (OPW'(p_wz) + OPW'(p_xy)) <<< 1;
      yaw_x  <= ONE - ((OPW'(p_yy) + OPW'(p_zz)) <<< 1);
      sine   <= (OPW'(p_wy) - OPW'(p_zx)) <<< 1;
    end
  end

  always_comb begin
    mag = sine[OPW-1] ? $unsigned(-sine) : $unsigned(sine);
    sat = (mag > $unsigned(ONE)) ? $unsigned(ONE) : mag;
    uw  = ({16'b0, sat} >> SHR) << SHL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1  <= uw[SQRT_BITS-1:0];
      sn1 <= sine[OPW-1];
      u2  <= u1;
      sn2 <= sn1;
      usq <= u1 * u1;
      sq[0].rem  <= REM_W'(UNIT_SQ - usq);
      sq[0].root <= '0;
      sq[0].yv   <= sn2 ? -UNIT_W'(u2) : UNIT_W'(u2);
    end
  end

  for (genvar g = 0; g < SQRT_BITS; g++) begin : g_sqrt
    qte_sqrt_cell #(.BIT(SQRT_BITS - 1 - g)) u_sqrt (
      .clk  (clk),
      .en   (en),
      .din  (sq[g]),
      .dout (sq[g+1])
    );
  end

  qte_atan2 #(.W(OPW), .ITER(CORDIC_ITERATIONS)) u_roll (
    .clk (clk), .en (en), .yv (roll_y), .xv (roll_x), .angle (roll_a)
  );

  qte_atan2 #(.W(OPW), .ITER(CORDIC_ITERATIONS)) u_yaw (
    .clk (clk), .en (en), .yv (yaw_y), .xv (yaw_x), .angle (yaw_a)
  );

  qte_atan2 #(.W(UNIT_W), .ITER(CORDIC_ITERATIONS)) u_pitch (
    .clk   (clk),
    .en    (en),
    .yv    (sq[SQRT_BITS].yv),
    .xv    (UNIT_W'(sq[SQRT_BITS].root)),
    .angle (pitch_a)
  );

  // roll and yaw wait for pitch
  always_ff @(posedge clk) begin
    if (en) begin
      roll_d[0] <= roll_a;
      yaw_d[0]  <= yaw_a;
      for (int k = 1; k < PITCH_LEAD; k++) begin
        roll_d[k] <= roll_d[k-1];
        yaw_d[k]  <= yaw_d[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= quat_valid;
      for (int k = 1; k < DEPTH; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pres[0] <= present;
      for (int k = 1; k < DEPTH - 1; k++) pres[k] <= pres[k-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      roll_cdeg  <= pres[DEPTH-2] ? roll_d[PITCH_LEAD-1] : '0;
      yaw_cdeg   <= pres[DEPTH-2] ? yaw_d[PITCH_LEAD-1] : '0;
      pitch_cdeg <= pres[DEPTH-2] ? pitch_a[14:0] : '0;
    end
  end

  a_roll_yaw_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (roll_cdeg >= -HALF_TURN) && (roll_cdeg <= HALF_TURN)
                 && (yaw_cdeg >= -HALF_TURN) && (yaw_cdeg <= HALF_TURN))
    else $error("roll or yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (AW'(pitch_cdeg) >= -QUARTER) && (AW'(pitch_cdeg) <= QUARTER))
    else $error("pitch out of range");

endmodule

[bench/quaternion_to_euler_angles_tb.sv]
// testbench for the quaternion to euler angle block: directed, random and back-pressure transfers
module quaternion_to_euler_angles_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITERATIONS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int LATENCY    = ITERATIONS + 41;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quat_valid = 1'b0;
  logic quat_stall;
  logic signed [15:0] quat_w = '0;
  logic signed [15:0] quat_x = '0;
  logic signed [15:0] quat_y = '0;
  logic signed [15:0] quat_z = '0;
  logic present = 1'b0;
  logic angle_valid;
  logic angle_stall = 1'b0;
  logic signed [15:0] roll_cdeg;
  logic signed [14:0] pitch_cdeg;
  logic signed [15:0] yaw_cdeg;

  angles_t pending_angles[$];
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  bit rx_quiet = 0;
  bit tx_quiet = 0;

  longint arctan_steps[24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  quaternion_to_euler_angles #(
    .CORDIC_ITERATIONS (ITERATIONS),
    .QUAT_FRACTION_BITS(FRAC_BITS)
  ) uut (.*);

  always #5 clk = ~clk;

  function automatic int atan2_cdeg(longint yv, longint xv);
    bit [63:0] ay, ax;
    longint xr, yr, zr, dx, dy;
    int a;
    ay = (yv < 0) ? -yv : yv;
    ax = (xv < 0) ? -xv : xv;
    if (ay == 0 && ax == 0) return 0;
    while ((ax | ay) < (64'd1 << 29)) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    while ((ax | ay) >= (64'd1 << 30)) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    xr = ax;
    yr = ay;
    zr = 0;
    for (int i = 0; i < ITERATIONS && i < 24; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr > 0) begin
        xr += dx;
        yr -= dy;
        zr += arctan_steps[i];
      end else if (yr < 0) begin
        xr -= dx;
        yr += dy;
        zr -= arctan_steps[i];
      end
    end
    if (zr < 0) zr = 0;
    if (zr > 64'sd589824000) zr = 589824000;
    a = int'((zr + 32768) >>> 16);
    if (xv < 0) a = 18000 - a;
    if (yv < 0) a = -a;
    return a;
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic angles_t euler_from_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                                             logic signed [15:0] qy, logic signed [15:0] qz,
                                             logic on);
    angles_t e;
    longint w, x, y, z, one, s;
    bit [63:0] m, u, c;
    int p;
    e.roll = '0;
    e.pitch = '0;
    e.yaw = '0;
    if (on) begin
      w = qw;
      x = qx;
      y = qy;
      z = qz;
      one = longint'(1) << (2 * FRAC_BITS);
      e.roll = 16'(atan2_cdeg(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
      e.yaw = 16'(atan2_cdeg(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
      s = 2 * (w * y - z * x);
      m = (s < 0) ? -s : s;
      if (m > one) m = one;
      if (2 * FRAC_BITS > 30) u = m >> (2 * FRAC_BITS - 30);
      else u = m << (30 - 2 * FRAC_BITS);
      c = floor_sqrt((64'd1 << 60) - u * u);
      p = atan2_cdeg(longint'(u), longint'(c));
      if (s < 0) p = -p;
      e.pitch = 15'(p);
    end
    return e;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                           logic signed [15:0] qy, logic signed [15:0] qz, logic on);
    @(negedge clk);
    quat_valid <= 1'b1;
    quat_w <= qw;
    quat_x <= qx;
    quat_y <= qy;
    quat_z <= qz;
    present <= on;
    do @(posedge clk); while (quat_stall);
    pending_angles.push_back(euler_from_quat(qw, qx, qy, qz, on));
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      quat_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  task automatic send_unit(real a, real b, real c, real d, logic on);
    real n;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0e-3) begin
      a = 1.0;
      n = 1.0;
    end
    send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
              16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)), on);
  endtask

  function automatic real rand_unit();
    return (real'($urandom_range(20000)) - 10000.0) / 10000.0;
  endfunction

  task automatic send_random_quat();
    int kind;
    real a, b;
    kind = $urandom_range(99);
    if (kind < 70) begin
      send_unit(rand_unit(), rand_unit(), rand_unit(), rand_unit(), 1'b1);
    end else if (kind < 82) begin
      // near gimbal lock, pitch close to plus or minus ninety
      a = rand_unit();
      b = rand_unit();
      if ($urandom_range(1)) send_unit(a, b, a + rand_unit() * 0.01, -b, 1'b1);
      else send_unit(a, b, -a, b + rand_unit() * 0.01, 1'b1);
    end else if (kind < 95) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    end else begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    end
  endtask

  task automatic test_directed();
    send_quat(16'sd16384, 0, 0, 0, 1'b1);
    send_quat(0, 0, 0, 0, 1'b1);
    send_quat(0, 16'sd16384, 0, 0, 1'b1);
    send_quat(0, 0, 16'sd16384, 0, 1'b1);
    send_quat(0, 0, 0, 16'sd16384, 1'b1);
    send_quat(0, -16'sd16384, 0, 0, 1'b1);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192, 1'b1);
    send_quat(16'sd8192, -16'sd8192, -16'sd8192, -16'sd8192, 1'b1);
    send_quat(16'sd11585, 0, 16'sd11585, 0, 1'b1);
    send_quat(16'sd11585, 0, -16'sd11585, 0, 1'b1);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1);
    send_quat(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b1);
    send_quat(0, 0, 16'sd32767, 16'sd32767, 1'b1);
    send_quat(-16'sd16384, 0, 0, 0, 1'b1);
    send_quat(16'sd1, 0, 0, 16'sd1, 1'b1);
    send_quat(16'sd16384, 16'sd1234, -16'sd4321, 16'sd777, 1'b0);
    send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        tx_quiet = ($urandom_range(3) == 0);
        rx_quiet = ($urandom_range(3) == 0);
      end
      send_random_quat();
      if (!tx_quiet) idle_sender(gap_length());
    end
    tx_quiet = 0;
    rx_quiet = 0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_left = 3 * LATENCY;
    for (int i = 0; i < 120; i++) send_random_quat();
    wait_drained();
  endtask

  task automatic test_pause_until_drained();
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 20; i++) send_random_quat();
      wait_drained();
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      angle_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (rx_quiet || rst) begin
      angle_stall <= 1'b0;
    end else if ($urandom_range(99) < 2) begin
      angle_stall <= 1'b1;
      hold_left <= $urandom_range(40, 10);
    end else begin
      angle_stall <= ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    angles_t e;
    if (!rst && angle_valid && !angle_stall) begin
      if (pending_angles.size() == 0) begin
        $error("angle transfer with nothing expected");
        errors++;
      end else begin
        e = pending_angles.pop_front();
        if (roll_cdeg !== e.roll) begin
          $error("roll_cdeg expected %0d got %0d", e.roll, roll_cdeg);
          errors++;
        end
        if (pitch_cdeg !== e.pitch) begin
          $error("pitch_cdeg expected %0d got %0d", e.pitch, pitch_cdeg);
          errors++;
        end
        if (yaw_cdeg !== e.yaw) begin
          $error("yaw_cdeg expected %0d got %0d", e.yaw, yaw_cdeg);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_pause_until_drained();
    test_random(1700);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && pending_angles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
